// ----- design/spherical_density_profile_macros.svh -----
// Assertion macros for the spherical density profile checker.
// No dependencies.
`ifndef SPHERICAL_DENSITY_PROFILE_MACROS_SVH
`define SPHERICAL_DENSITY_PROFILE_MACROS_SVH

// same-cycle implication
`define SDP_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sdp check failed");

// next-cycle implication
`define SDP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sdp check failed");

`endif

// ----- design/sdp_pkg.sv -----
// Shared types and constants for the spherical density profile.
// No dependencies.
`timescale 1ns / 1ps
package sdp_pkg;
   localparam int SDP_NUM_BINS_MAX = 64;
   localparam int QUEUE_DEPTH      = 4;
   localparam int NUM_BINS_W       = 7;
   localparam int BIN_INDEX_W      = 6;
   localparam int DATA_W           = 32;
   localparam int MASS_W           = 56;
   localparam int DENS_W           = 48;
   localparam int QUO_W            = 72;
   localparam int DIV_W            = 14;
   localparam int CNT_W            = 7;
   localparam int PADDR_W          = 4;

   localparam logic [1:0] REG_NUM_BINS      = 2'd0;
   localparam logic [1:0] REG_INV_BIN_WIDTH = 2'd1;
   localparam logic [1:0] REG_DENSITY_SCALE = 2'd2;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [BIN_INDEX_W-1:0] bin;
      logic [DATA_W-1:0]      mass;
   } q_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_E_RD,
      ST_E_MLO,
      ST_E_MHI,
      ST_E_SUM,
      ST_E_DIV,
      ST_E_OUT
   } state_type;
endpackage

// ----- design/spherical_density_profile.sv -----
// Add beat: held in the front stage, then in the back end the bin store
// is read, then written; the next entry is taken only after the write.
// Emit beat per bin in use: read, two multiply halves, sum, 72-step
// bit-serial divider, output load. Reset (synchronous, active high)
// clears queue and store valid bits and sets config to its defaults.
`timescale 1ns / 1ps
module spherical_density_profile
   import sdp_pkg::*;
#(
   parameter int NUM_BINS_MAX = SDP_NUM_BINS_MAX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [DATA_W-1:0]      req_radius,
   input  logic [DATA_W-1:0]      req_mass,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BIN_INDEX_W-1:0] rsp_bin_index,
   output logic [MASS_W-1:0]      rsp_bin_mass,
   output logic [DENS_W-1:0]      rsp_density,
   output logic                   rsp_last,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [PADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]      csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);
   logic [NUM_BINS_W-1:0] num_bins_ff;
   logic [DATA_W-1:0]     inv_bin_width_ff;
   logic [DATA_W-1:0]     density_scale_ff;
   logic [NUM_BINS_W-1:0] n_eff;
   logic [1:0]            reg_idx;
   logic                  csr_wr;
   logic                  push_valid;
   q_entry_type           push_entry;
   logic                  q_full;
   logic                  q_valid;
   q_entry_type           q_entry;
   logic                  pop;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      if (num_bins_ff == '0) begin
         n_eff = NUM_BINS_W'(1);
      end else if (num_bins_ff > NUM_BINS_W'(NUM_BINS_MAX)) begin
         n_eff = NUM_BINS_W'(NUM_BINS_MAX);
      end else begin
         n_eff = num_bins_ff;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_NUM_BINS:      csr_prdata = {{(DATA_W-NUM_BINS_W){1'b0}}, num_bins_ff};
         REG_INV_BIN_WIDTH: csr_prdata = inv_bin_width_ff;
         REG_DENSITY_SCALE: csr_prdata = density_scale_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff      <= NUM_BINS_W'(64);
         inv_bin_width_ff <= DATA_W'(65536);
         density_scale_ff <= DATA_W'(65536);
      end else if (csr_wr) begin
         case (reg_idx)
            REG_NUM_BINS:      num_bins_ff      <= csr_pwdata[NUM_BINS_W-1:0];
            REG_INV_BIN_WIDTH: inv_bin_width_ff <= csr_pwdata;
            REG_DENSITY_SCALE: density_scale_ff <= csr_pwdata;
            default:           num_bins_ff      <= num_bins_ff;
         endcase
      end
   end

   sdp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_radius    (req_radius),
      .req_mass      (req_mass),
      .inv_bin_width (inv_bin_width_ff),
      .n_eff         (n_eff),
      .push_valid    (push_valid),
      .q_full        (q_full),
      .push_entry    (push_entry)
   );

   sdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   sdp_back #(
      .NUM_BINS_MAX (NUM_BINS_MAX)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .pop           (pop),
      .density_scale (density_scale_ff),
      .n_eff         (n_eff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_mass  (rsp_bin_mass),
      .rsp_density   (rsp_density),
      .rsp_last      (rsp_last)
   );
endmodule

// ----- design/sdp_front.sv -----
// Front end: takes request beats, bins the radius and drops out-of-range adds.
// Depends on sdp_pkg.
`timescale 1ns / 1ps
module sdp_front
   import sdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [DATA_W-1:0]     req_radius,
   input  logic [DATA_W-1:0]     req_mass,
   input  logic [DATA_W-1:0]     inv_bin_width,
   input  logic [NUM_BINS_W-1:0] n_eff,
   output logic                  push_valid,
   input  logic                  q_full,
   output q_entry_type           push_entry
);
   logic              s_valid_ff;
   logic              s_cmd_ff;
   logic [DATA_W-1:0] s_radius_ff;
   logic [DATA_W-1:0] s_mass_ff;
   logic [2*DATA_W-1:0] prod;
   logic              in_range;
   logic              consume;

   assign prod     = s_radius_ff * inv_bin_width;
   assign in_range = prod[2*DATA_W-1:DATA_W] < {{(DATA_W-NUM_BINS_W){1'b0}}, n_eff};

   assign push_valid = s_valid_ff && (s_cmd_ff == CMD_EMIT || in_range);
   // a dropped add leaves the stage without touching the queue
   assign consume    = s_valid_ff && (!q_full || !push_valid);
   assign req_ready  = !s_valid_ff || consume;

   always_comb begin
      push_entry.cmd  = s_cmd_ff;
      push_entry.bin  = prod[DATA_W +: BIN_INDEX_W];
      push_entry.mass = s_mass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s_cmd_ff    <= req_cmd;
         s_radius_ff <= req_radius;
         s_mass_ff   <= req_mass;
      end
   end
endmodule

// ----- design/sdp_queue.sv -----
// Small FIFO between front and back ends.
// Depends on sdp_pkg.
`timescale 1ns / 1ps
module sdp_queue
   import sdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  q_entry_type push_entry,
   output logic        q_full,
   input  logic        pop,
   output logic        q_valid,
   output q_entry_type q_entry
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   q_entry_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign q_full  = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_entry = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
      end
      if (do_push) entries_ff[wr_ptr_ff] <= push_entry;
   end
endmodule

// ----- design/sdp_back.sv -----
// Back end: bin store read-modify-write and the emit sequencer with a
// split multiplier and a bit-serial divider. Depends on sdp_pkg.
`timescale 1ns / 1ps
module sdp_back
   import sdp_pkg::*;
#(
   parameter int NUM_BINS_MAX = SDP_NUM_BINS_MAX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  q_entry_type            q_entry,
   output logic                   pop,
   input  logic [DATA_W-1:0]      density_scale,
   input  logic [NUM_BINS_W-1:0]  n_eff,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BIN_INDEX_W-1:0] rsp_bin_index,
   output logic [MASS_W-1:0]      rsp_bin_mass,
   output logic [DENS_W-1:0]      rsp_density,
   output logic                   rsp_last
);
   localparam int ADDR_W = (NUM_BINS_MAX > 1) ? $clog2(NUM_BINS_MAX) : 1;

   state_type state_ff, state_in;

   logic [MASS_W-1:0]       mem [NUM_BINS_MAX];
   logic [NUM_BINS_MAX-1:0] valid_ff;
   logic [MASS_W-1:0]       rd_ff;
   logic                    rd_vld_ff;
   logic [MASS_W-1:0]       rd_eff;
   q_entry_type             cur_ff;
   logic [BIN_INDEX_W-1:0]  idx_ff;
   logic [ADDR_W-1:0]       addr;
   logic [MASS_W-1:0]       mass_ff;
   logic [2*DATA_W-1:0]     pp_lo_ff;
   logic [MASS_W-1:0]       pp_hi_ff;
   logic [MASS_W+DATA_W-1:0] prod_sum;
   logic [QUO_W-1:0]        num_ff;
   logic [DIV_W-1:0]        rem_ff;
   logic [DIV_W-1:0]        d_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [DIV_W:0]          trial;
   logic                    ge;
   logic [DIV_W:0]          trial_sub;
   logic [MASS_W:0]         add_sum;
   logic [MASS_W-1:0]       add_sat;
   logic [2*BIN_INDEX_W:0]  sq;
   logic [DIV_W-1:0]        d_calc;
   logic                    is_last;
   logic                    out_free;
   logic                    rsp_valid_ff;
   logic                    do_write;
   logic                    load_out;

   assign rd_eff    = rd_vld_ff ? rd_ff : '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = ({1'b0, idx_ff} + 1'b1) == n_eff;
   assign addr      = (state_ff == ST_IDLE) ? q_entry.bin[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];

   assign add_sum   = {1'b0, rd_eff} + {{(MASS_W-DATA_W+1){1'b0}}, cur_ff.mass};
   assign add_sat   = add_sum[MASS_W] ? {MASS_W{1'b1}} : add_sum[MASS_W-1:0];

   // shell factor 3i(i+1)+1
   assign sq        = idx_ff * ({1'b0, idx_ff} + 1'b1);
   assign d_calc    = DIV_W'({sq, 1'b0}) + DIV_W'(sq) + DIV_W'(1);

   assign prod_sum  = {pp_hi_ff, {DATA_W{1'b0}}} + {{(MASS_W-DATA_W){1'b0}}, pp_lo_ff};

   assign trial     = {rem_ff, num_ff[QUO_W-1]};
   assign ge        = trial >= {1'b0, d_ff};
   assign trial_sub = trial - {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = (q_entry.cmd == CMD_EMIT) ? ST_E_RD : ST_ADD_WR;
         end
         ST_ADD_WR: state_in = ST_IDLE;
         ST_E_RD:   state_in = ST_E_MLO;
         ST_E_MLO:  state_in = ST_E_MHI;
         ST_E_MHI:  state_in = ST_E_SUM;
         ST_E_SUM:  state_in = ST_E_DIV;
         ST_E_DIV: begin
            if (cnt_ff == CNT_W'(1)) state_in = ST_E_OUT;
         end
         ST_E_OUT: begin
            if (out_free) state_in = is_last ? ST_IDLE : ST_E_RD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      do_write = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE:   pop      = q_valid;
         ST_ADD_WR: do_write = 1'b1;
         ST_E_OUT:  load_out = out_free;
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_write) valid_ff[cur_ff.bin[ADDR_W-1:0]] <= 1'b1;
         // emit clears the whole store on its final beat
         if (load_out && is_last) valid_ff <= '0;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff     <= mem[addr];
      rd_vld_ff <= valid_ff[addr];
      if (do_write) mem[cur_ff.bin[ADDR_W-1:0]] <= add_sat;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_entry;
         idx_ff <= '0;
      end
      case (state_ff)
         ST_E_RD:  d_ff <= d_calc;
         ST_E_MLO: begin
            mass_ff  <= rd_eff;
            pp_lo_ff <= rd_eff[DATA_W-1:0] * density_scale;
         end
         ST_E_MHI: pp_hi_ff <= mass_ff[MASS_W-1:DATA_W] * density_scale;
         ST_E_SUM: begin
            num_ff <= prod_sum[MASS_W+DATA_W-1:16];
            rem_ff <= '0;
            cnt_ff <= CNT_W'(QUO_W);
         end
         ST_E_DIV: begin
            num_ff <= {num_ff[QUO_W-2:0], ge};
            rem_ff <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_E_OUT: begin
            if (load_out) begin
               rsp_bin_index <= idx_ff;
               rsp_bin_mass  <= mass_ff;
               rsp_density   <= (|num_ff[QUO_W-1:DENS_W]) ? {DENS_W{1'b1}}
                                                          : num_ff[DENS_W-1:0];
               rsp_last      <= is_last;
               idx_ff        <= idx_ff + 1'b1;
            end
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- design/sdp_checker.sv -----
// Port-level checks for spherical_density_profile, attached by bind.
// Depends on sdp_pkg and spherical_density_profile_macros.svh.
`timescale 1ns / 1ps
`include "spherical_density_profile_macros.svh"
module sdp_checker
   import sdp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [BIN_INDEX_W-1:0] rsp_bin_index,
   input logic [MASS_W-1:0]      rsp_bin_mass,
   input logic [DENS_W-1:0]      rsp_density,
   input logic                   rsp_last
);
   // a stalled result beat holds
   `SDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bin_mass) && $stable(rsp_density) && $stable(rsp_bin_index) && $stable(rsp_last))
   // within a run, a beat that follows at once is the next bin
   `SDP_ASSERT_NEXT(a_rsp_next_bin, clock, reset, rsp_valid && rsp_ready && !rsp_last, !rsp_valid || rsp_bin_index == $past(rsp_bin_index) + 1'b1)
   // a run starts again from bin 0
   `SDP_ASSERT_NEXT(a_rsp_run_start, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid || rsp_bin_index == '0)
   // an empty bin has zero density
   `SDP_ASSERT_IMPLY(a_zero_dens, clock, reset, rsp_valid && rsp_bin_mass == '0, rsp_density == '0)
endmodule

bind spherical_density_profile sdp_checker u_sdp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_bin_index (rsp_bin_index),
   .rsp_bin_mass  (rsp_bin_mass),
   .rsp_density   (rsp_density),
   .rsp_last      (rsp_last)
);
